/* rtl/core/pcsm_pkg.sv */
`default_nettype none
package pcsm_pkg;
  localparam int AW = 12;
  localparam int DW = 32;
  localparam int StackDepth = 4096;

  typedef logic [AW-1:0] addr_t;
  typedef logic [DW-1:0] data_t;

  localparam logic [2:0] M_LIT = 3'd0;
  localparam logic [2:0] M_LOD = 3'd1;
  localparam logic [2:0] M_STO = 3'd2;
  localparam logic [2:0] M_CAL = 3'd3;
  localparam logic [2:0] M_INT = 3'd4;
  localparam logic [2:0] M_JMP = 3'd5;
  localparam logic [2:0] M_JPC = 3'd6;
  localparam logic [2:0] M_OPR = 3'd7;

  localparam logic [31:0] F_RET = 32'd0;
  localparam logic [31:0] F_NEG = 32'd1;
  localparam logic [31:0] F_ADD = 32'd2;
  localparam logic [31:0] F_SUB = 32'd3;
  localparam logic [31:0] F_MUL = 32'd4;
  localparam logic [31:0] F_DIV = 32'd5;
  localparam logic [31:0] F_ODD = 32'd6;
  localparam logic [31:0] F_EQ  = 32'd8;
  localparam logic [31:0] F_NE  = 32'd9;
  localparam logic [31:0] F_LT  = 32'd10;
  localparam logic [31:0] F_GE  = 32'd11;
  localparam logic [31:0] F_GT  = 32'd12;
  localparam logic [31:0] F_LE  = 32'd13;
  localparam logic [31:0] F_PRT = 32'd14;
  localparam logic [31:0] F_NL  = 32'd15;
  localparam logic [31:0] F_RD  = 32'd16;

  typedef struct packed {
    logic start;
    logic [DW-1:0] a;
    logic [DW-1:0] b;
  } div_req_t;

  typedef struct packed {
    logic done;
    logic [DW-1:0] q;
  } div_rsp_t;
endpackage
`default_nettype wire

/* rtl/core/pcsm_if.sv */
`default_nettype none
interface pcsm_in_if;
  logic valid;
  logic ready;
  logic [2:0] mode;
  logic [7:0] level_diff;
  logic signed [31:0] operand;
  logic signed [31:0] read_value;
  modport source (output valid, mode, level_diff, operand, read_value, input ready);
  modport sink (input valid, mode, level_diff, operand, read_value, output ready);
endinterface

interface pcsm_out_if;
  logic valid;
  logic ready;
  logic [11:0] next_pc;
  logic print_valid;
  logic signed [31:0] print_value;
  logic newline;
  logic halted;
  logic error_flag;
  modport source (output valid, next_pc, print_valid, print_value, newline, halted,
                  error_flag, input ready);
  modport sink (input valid, next_pc, print_valid, print_value, newline, halted,
                error_flag, output ready);
endinterface
`default_nettype wire

/* rtl/core/pcsm_div.sv */
`default_nettype none
// Radix-2 restoring divider on magnitudes, one quotient bit per cycle.
module pcsm_div
  import pcsm_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire div_req_t req_i,
  output div_rsp_t      rsp_o
);
  logic [DW-1:0] rem_q, rem_d, quo_q, quo_d, den_q, den_d;
  logic [5:0] cnt_q, cnt_d;
  logic busy_q, busy_d, neg_q, neg_d, done_q, done_d;
  logic [DW:0] trial;
  logic [DW-1:0] shr;

  always_comb begin
    rem_d = rem_q; quo_d = quo_q; den_d = den_q; cnt_d = cnt_q;
    busy_d = busy_q; neg_d = neg_q; done_d = 1'b0;
    shr = {rem_q[DW-2:0], quo_q[DW-1]};
    trial = {1'b0, shr} - {1'b0, den_q};
    if (req_i.start) begin
      rem_d = '0;
      quo_d = req_i.a[DW-1] ? (~req_i.a + 1'b1) : req_i.a;
      den_d = req_i.b[DW-1] ? (~req_i.b + 1'b1) : req_i.b;
      neg_d = req_i.a[DW-1] ^ req_i.b[DW-1];
      cnt_d = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[DW]) begin
        rem_d = trial[DW-1:0];
        quo_d = {quo_q[DW-2:0], 1'b1};
      end else begin
        rem_d = shr;
        quo_d = {quo_q[DW-2:0], 1'b0};
      end
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == 6'(DW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
    neg_q <= neg_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.q    = neg_q ? (~quo_q + 1'b1) : quo_q;
endmodule
`default_nettype wire

/* rtl/core/pcsm_stack_ram.sv */
`default_nettype none
module pcsm_stack_ram
  import pcsm_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  we_i,
  input  wire addr_t waddr_i,
  input  wire data_t wdata_i,
  input  wire addr_t raddr_i,
  output data_t      rdata_o
);
  data_t mem [StackDepth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule
`default_nettype wire

/* rtl/core/pcode_stack_machine_top.sv */
`default_nettype none
// Channel   Dir  Payload
// in_if     in   mode, level_diff, operand, read_value
// out_if    out  next_pc, print_valid, print_value, newline, halted, error_flag
//
// One instruction at a time; ready is low from acceptance until the result is taken.
// Each stack read goes through the single registered read port of the stack RAM;
// LOD/STO/CAL follow the static links one by one, and divide waits on the
// radix-2 divider in pcsm_div.
// Reset: top 0, base 1, pc 0; stack entries 1 to 3 are then written as zero in
// S_INIT, during which no instruction is taken.
module pcode_stack_machine_top
  import pcsm_pkg::*;
(
  input wire logic clk_i,
  input wire logic rst_ni,
  pcsm_in_if.sink    in_if,
  pcsm_out_if.source out_if
);
  typedef enum logic [9:0] {
    S_INIT  = 10'b0000000001,
    S_IDLE  = 10'b0000000010,
    S_DEC   = 10'b0000000100,
    S_CHAIN = 10'b0000001000,
    S_RD1   = 10'b0000010000,
    S_RD2   = 10'b0000100000,
    S_EXEC  = 10'b0001000000,
    S_DIV   = 10'b0010000000,
    S_CAL   = 10'b0100000000,
    S_OUT   = 10'b1000000000
  } state_e;

  state_e state_q, state_d;
  addr_t top_q, top_d, base_q, base_d, pc_q, pc_d;
  logic [2:0] mode_q;
  logic [7:0] lev_q, lev_d;
  data_t opnd_q, rv_q;
  logic [1:0] init_q, init_d, step_q, step_d;
  logic wait_q, wait_d;
  data_t x_q, x_d;
  data_t cb_q, cb_d;
  logic err_q, err_d, pv_q, pv_d, nl_q, nl_d;
  data_t pval_q, pval_d;

  logic we;
  addr_t waddr, raddr_q, raddr_d;
  data_t wdata, rdata;
  div_req_t dreq;
  div_rsp_t drsp;

  pcsm_stack_ram u_ram (.clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
                        .raddr_i(raddr_d), .rdata_o(rdata));
  pcsm_div u_div (.clk_i, .rst_ni, .req_i(dreq), .rsp_o(drsp));

  // address range check: value is a (DW+1)-bit signed index
  function automatic logic oor(input logic signed [DW:0] a);
    oor = (a < 0) || (a >= (DW+1)'(StackDepth));
  endfunction

  logic signed [DW:0] sx_top, sx_opnd, sx_cb, sum_a;
  assign sx_top  = (DW+1)'(top_q);
  assign sx_opnd = {opnd_q[DW-1], opnd_q};
  assign sx_cb   = {cb_q[DW-1], cb_q};

  // saved base on return, zero when base+1 is past the end of the stack RAM
  data_t link_b;
  assign link_b = (base_q == '1) ? '0 : rdata;

  logic is_bin;
  assign is_bin = (opnd_q == F_ADD) || (opnd_q == F_SUB) || (opnd_q == F_MUL) ||
                  (opnd_q == F_DIV) || (opnd_q == F_EQ) || (opnd_q == F_NE) ||
                  (opnd_q == F_LT) || (opnd_q == F_GE) || (opnd_q == F_GT) ||
                  (opnd_q == F_LE);

  logic signed [DW-1:0] sa, sb;
  assign sa = signed'(x_q);
  assign sb = signed'(rdata);

  always_comb begin
    state_d = state_q; top_d = top_q; base_d = base_q; pc_d = pc_q;
    lev_d = lev_q; init_d = init_q; step_d = step_q; wait_d = 1'b0;
    x_d = x_q; cb_d = cb_q; err_d = err_q; pv_d = pv_q; nl_d = nl_q;
    pval_d = pval_q; raddr_d = raddr_q;
    we = 1'b0; waddr = '0; wdata = '0; sum_a = '0;
    dreq = '0;
    case (state_q)
      S_INIT: begin
        we = 1'b1; waddr = addr_t'(init_q) + addr_t'(1);
        init_d = init_q + 2'd1;
        if (init_q == 2'd2) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_if.valid) begin
          state_d = S_DEC; lev_d = in_if.level_diff;
          err_d = 1'b0; pv_d = 1'b0; nl_d = 1'b0; pval_d = '0;
          pc_d = pc_q + addr_t'(1); cb_d = data_t'(base_q); step_d = '0;
        end
      end
      S_DEC: begin
        case (mode_q)
          M_LIT: begin
            sum_a = sx_top + 1;
            if (oor(sum_a)) err_d = 1'b1;
            else begin we = 1'b1; waddr = addr_t'(sum_a); wdata = opnd_q; end
            top_d = addr_t'(sum_a); state_d = S_OUT;
          end
          M_INT: begin
            sum_a = sx_top + sx_opnd;
            if (oor(sum_a)) err_d = 1'b1;
            top_d = addr_t'(sum_a); state_d = S_OUT;
          end
          M_JMP: begin
            pc_d = addr_t'(opnd_q); state_d = S_OUT;
          end
          M_LOD, M_STO, M_CAL: begin
            state_d = S_CHAIN; wait_d = 1'b0; raddr_d = base_q;
          end
          M_JPC: begin
            raddr_d = top_q; state_d = S_RD2; wait_d = 1'b1;
          end
          default: begin
            if (opnd_q == F_RET) begin
              raddr_d = base_q + addr_t'(2); state_d = S_RD1; wait_d = 1'b1;
              if (oor((DW+1)'(base_q) + 2)) err_d = 1'b1;
            end else if (opnd_q == F_NL) begin
              nl_d = 1'b1; state_d = S_OUT;
            end else if (opnd_q == F_RD) begin
              sum_a = sx_top + 1;
              if (oor(sum_a)) err_d = 1'b1;
              else begin we = 1'b1; waddr = addr_t'(sum_a); wdata = rv_q; end
              top_d = addr_t'(sum_a); state_d = S_OUT;
            end else if (is_bin) begin
              sum_a = sx_top - 1;
              if (oor(sum_a)) err_d = 1'b1;
              raddr_d = addr_t'(sum_a); state_d = S_RD1; wait_d = 1'b1;
            end else if ((opnd_q == F_NEG) || (opnd_q == F_ODD) || (opnd_q == F_PRT)) begin
              raddr_d = top_q; state_d = S_RD2; wait_d = 1'b1;
            end else begin
              state_d = S_OUT;
            end
          end
        endcase
      end
      S_CHAIN: begin
        // raddr holds current base; a read is issued, result next cycle
        if (wait_q) begin
          cb_d = rdata;
          lev_d = lev_q - 8'd1; raddr_d = addr_t'(rdata);
        end else if (lev_q != 8'd0) begin
          if (oor(sx_cb)) begin
            // link outside the stack reads as zero
            err_d = 1'b1; cb_d = '0; lev_d = lev_q - 8'd1; raddr_d = '0;
          end else begin
            wait_d = 1'b1;
          end
        end else begin
          if (mode_q == M_CAL) begin
            state_d = S_CAL;
          end else if (mode_q == M_LOD) begin
            sum_a = sx_cb + sx_opnd;
            if (oor(sum_a)) err_d = 1'b1;
            raddr_d = addr_t'(sum_a); state_d = S_RD2; wait_d = 1'b1;
          end else begin
            raddr_d = top_q; state_d = S_RD2; wait_d = 1'b1;
          end
        end
      end
      S_RD1: begin
        // first operand (t-1 for binary, return address for return)
        if (wait_q) begin
          x_d = rdata;
          if (mode_q == M_OPR && opnd_q == F_RET) begin
            if (oor((DW+1)'(base_q) + 2)) x_d = '0;
            raddr_d = base_q + addr_t'(1);
            if (oor((DW+1)'(base_q) + 1)) err_d = 1'b1;
          end else begin
            raddr_d = top_q;
          end
          wait_d = 1'b1; state_d = S_RD2;
        end
      end
      S_RD2: begin
        if (wait_q) state_d = S_EXEC;
      end
      S_EXEC: begin
        state_d = S_OUT;
        case (mode_q)
          M_LOD: begin
            sum_a = sx_top + 1;
            if (oor(sum_a)) err_d = 1'b1;
            else begin
              we = 1'b1; waddr = addr_t'(sum_a);
              wdata = oor(sx_cb + sx_opnd) ? '0 : rdata;
            end
            top_d = addr_t'(sum_a);
          end
          M_STO: begin
            sum_a = sx_cb + sx_opnd;
            if (oor(sum_a)) err_d = 1'b1;
            else begin we = 1'b1; waddr = addr_t'(sum_a); wdata = rdata; end
            if (oor(sx_top - 1)) err_d = 1'b1;
            top_d = top_q - addr_t'(1);
          end
          M_JPC: begin
            if (rdata == '0) pc_d = addr_t'(opnd_q);
            if (oor(sx_top - 1)) err_d = 1'b1;
            top_d = top_q - addr_t'(1);
          end
          default: begin
            if (opnd_q == F_RET) begin
              // x = return address (base+2), link_b = saved base (base+1)
              pc_d = addr_t'(x_q);
              if (oor({link_b[DW-1], link_b})) err_d = 1'b1;
              base_d = addr_t'(link_b);
              sum_a = (DW+1)'(base_q) - 1;
              if (oor(sum_a)) err_d = 1'b1;
              top_d = addr_t'(sum_a);
            end else if (opnd_q == F_NEG) begin
              we = 1'b1; waddr = top_q; wdata = '0 - rdata;
            end else if (opnd_q == F_ODD) begin
              we = 1'b1; waddr = top_q; wdata = data_t'(rdata[0]);
            end else if (opnd_q == F_PRT) begin
              pv_d = 1'b1; pval_d = rdata;
              if (oor(sx_top - 1)) err_d = 1'b1;
              top_d = top_q - addr_t'(1);
            end else begin
              sum_a = sx_top - 1;
              if (oor(sum_a)) err_d = 1'b1;
              top_d = addr_t'(sum_a);
              we = !oor(sum_a); waddr = addr_t'(sum_a);
              if (opnd_q == F_ADD) wdata = x_q + rdata;
              else if (opnd_q == F_SUB) wdata = x_q - rdata;
              else if (opnd_q == F_MUL) wdata = x_q * rdata;
              else if (opnd_q == F_EQ) wdata = data_t'(sa == sb);
              else if (opnd_q == F_NE) wdata = data_t'(sa != sb);
              else if (opnd_q == F_LT) wdata = data_t'(sa < sb);
              else if (opnd_q == F_GE) wdata = data_t'(sa >= sb);
              else if (opnd_q == F_GT) wdata = data_t'(sa > sb);
              else if (opnd_q == F_LE) wdata = data_t'(sa <= sb);
              else begin
                if (rdata == '0) err_d = 1'b1;
                else if (rdata == '1) wdata = '0 - x_q;
                else begin
                  we = 1'b0; dreq.start = 1'b1; dreq.a = x_q; dreq.b = rdata;
                  state_d = S_DIV;
                end
              end
            end
          end
        endcase
      end
      S_DIV: begin
        // err here means t-1 fell below the stack, so the write is dropped
        if (drsp.done) begin
          we = !err_q; waddr = top_q; wdata = drsp.q; state_d = S_OUT;
        end
      end
      S_CAL: begin
        sum_a = sx_top + 1 + (DW+1)'(step_q);
        if (oor(sum_a)) err_d = 1'b1;
        else begin
          we = 1'b1; waddr = addr_t'(sum_a);
          case (step_q)
            2'd0:    wdata = cb_q;
            2'd1:    wdata = data_t'(base_q);
            default: wdata = data_t'(pc_q);
          endcase
        end
        step_d = step_q + 2'd1;
        if (step_q == 2'd2) begin
          if (oor(sx_top + 1)) err_d = 1'b1;
          base_d = top_q + addr_t'(1); pc_d = addr_t'(opnd_q); state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (out_if.ready) state_d = S_IDLE;
      end
      default: state_d = S_INIT;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT; top_q <= '0; base_q <= addr_t'(1); pc_q <= '0;
      init_q <= '0; wait_q <= 1'b0; step_q <= '0; err_q <= 1'b0;
      pv_q <= 1'b0; nl_q <= 1'b0; lev_q <= '0;
    end else begin
      state_q <= state_d; top_q <= top_d; base_q <= base_d; pc_q <= pc_d;
      init_q <= init_d; wait_q <= wait_d; step_q <= step_d; err_q <= err_d;
      pv_q <= pv_d; nl_q <= nl_d; lev_q <= lev_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_if.valid) begin
      mode_q <= in_if.mode; opnd_q <= in_if.operand; rv_q <= in_if.read_value;
    end
    x_q <= x_d; cb_q <= cb_d; pval_q <= pval_d; raddr_q <= raddr_d;
  end

  assign in_if.ready          = (state_q == S_IDLE);
  assign out_if.valid         = (state_q == S_OUT);
  assign out_if.next_pc       = pc_q;
  assign out_if.print_valid   = pv_q;
  assign out_if.print_value   = pval_q;
  assign out_if.newline       = nl_q;
  assign out_if.halted        = (pc_q == '0);
  assign out_if.error_flag    = err_q;

  ap_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_if.ready && out_if.valid)) else $error("ready while result pending");
  ap_pc_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && !out_if.ready |=> $stable(pc_q) && out_if.valid)
    else $error("result changed under stall");
  ap_one_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && out_if.ready |=> in_if.ready) else $error("no return to idle");
endmodule
`default_nettype wire
